### design/lfss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfss_pkg
// Shared widths and constants for the largest free square scanner.
// ----------------------------------------------------------------------------
package lfss_pkg;

    // Width of a square side and of the row length register
    localparam int SIDE_W = 11;
    localparam int LEN_W  = 11;

    // Largest side that fits in the side field
    localparam logic [SIDE_W-1:0] SIDE_MAX = {SIDE_W{1'b1}};

    // Row length after reset
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);

    typedef logic [SIDE_W-1:0] side_t;
    typedef logic [LEN_W-1:0]  len_t;

endpackage

### design/lfss_cell_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfss_cell_if
// Valid/ready channel carrying one grid cell per transfer.
// ----------------------------------------------------------------------------
interface lfss_cell_if;
    logic valid;
    logic ready;
    logic blocked;
    logic last_cell;

    modport source (output valid, output blocked, output last_cell, input ready);
    modport sink   (input valid, input blocked, input last_cell, output ready);
endinterface

### design/lfss_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfss_result_if
// Valid/ready channel carrying one scan result per transfer.
// ----------------------------------------------------------------------------
interface lfss_result_if
    import lfss_pkg::*;
;
    logic  valid;
    logic  ready;
    side_t square_side;
    side_t largest_side;
    logic  grid_done;

    modport source (output valid, output square_side, output largest_side,
                    output grid_done, input ready);
    modport sink   (input valid, input square_side, input largest_side,
                    input grid_done, output ready);
endinterface

### design/lfss_line_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfss_line_store
// Previous-row score memory: one write port, one registered read port,
// with forwarding of a write that lands on the entry being read.
// ----------------------------------------------------------------------------
module lfss_line_store
    import lfss_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  side_t                    wr_data,
    output side_t                    rd_data
);

    side_t mem [DEPTH];
    side_t mem_q_reg;
    logic  fwd_reg;
    side_t fwd_data_reg;
    logic  fwd_next;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // Detect a read of the entry written on the same edge
    assign fwd_next = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en && fwd_next)
        begin
            fwd_data_reg <= wr_data;
        end
    end

    // Select forwarded data over stale array data
    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;

endmodule

### design/largest_free_square_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_free_square_scan
// Streams a binary grid in row-major order and reports, per cell, the side of
// the largest free square ending there and the largest side so far.
// ----------------------------------------------------------------------------
// Takes one cell per clock while the result side accepts. A cell passes through
// stage one and then the result register before its result is valid. The rate
// is set by the line store: each cell does one read at transfer and one write
// when it leaves stage one, and a write to the entry being read on the same
// edge is forwarded, so back-to-back cells in a one-column grid work.
// The result register lets a new cell in while a result waits. The line store
// needs no clearing after reset; the row length register resets to 1024 and
// the user must write it only while the block is idle, which the block does
// not enforce. A zero length acts as one, one above MAX_COLUMNS as MAX_COLUMNS.
// ----------------------------------------------------------------------------
module largest_free_square_scan
    import lfss_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  len_t                 cfg_wr_data,
    lfss_cell_if.sink            cell_in,
    lfss_result_if.source        result_out
);

    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int EW = (LEN_W > CW + 1) ? LEN_W : CW + 1;

    localparam logic [EW-1:0] MAX_LEN = EW'(MAX_COLUMNS);

    // Configuration and front-end position
    len_t          len_reg;
    logic [CW-1:0] col_reg;
    logic          first_row_reg;

    // Stage one: cell waiting on the line store read
    logic          s1_valid_reg;
    logic          s1_blocked_reg;
    logic          s1_last_reg;
    logic          s1_edge_reg;
    logic          s1_wrap_reg;
    logic [CW-1:0] s1_col_reg;

    // Neighbor scores and running maximum
    side_t left_reg;
    side_t diag_reg;
    side_t max_reg;

    // Result register
    logic  out_valid_reg;
    side_t out_side_reg;
    side_t out_largest_reg;
    logic  out_done_reg;

    logic [EW-1:0] eff_len;
    logic [EW-1:0] next_col;
    logic          wrap;
    logic          accept;
    logic          s1_adv;
    side_t         up;
    side_t         min_ul;
    side_t         min3;
    side_t         score;
    side_t         max_next;

    // Clamp the row length into the usable range
    always_comb
    begin
        priority if (len_reg == '0)
        begin
            eff_len = EW'(1);
        end
        else if (EW'(len_reg) > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = EW'(len_reg);
        end
    end

    // Handshake: advance stage one when the result register frees up
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign cell_in.ready = !s1_valid_reg || s1_adv;
    assign accept        = cell_in.valid && cell_in.ready;

    assign next_col = EW'(col_reg) + EW'(1);
    assign wrap     = (next_col >= eff_len);

    // Score the cell in stage one
    always_comb
    begin
        min_ul = (up < left_reg) ? up : left_reg;
        min3   = (min_ul < diag_reg) ? min_ul : diag_reg;
        priority if (s1_blocked_reg)
        begin
            score = '0;
        end
        else if (s1_edge_reg)
        begin
            score = SIDE_W'(1);
        end
        else if (min3 == SIDE_MAX)
        begin
            score = SIDE_MAX;
        end
        else
        begin
            score = min3 + SIDE_W'(1);
        end
        max_next = (score > max_reg) ? score : max_reg;
    end

    lfss_line_store #(
        .DEPTH (MAX_COLUMNS)
    ) u_line_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (score),
        .rd_data (up)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= LEN_RESET;
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            s1_valid_reg  <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end

            // Advance the column on each cell transfer
            if (accept)
            begin
                priority if (cell_in.last_cell)
                begin
                    col_reg       <= '0;
                    first_row_reg <= 1'b1;
                end
                else if (wrap)
                begin
                    col_reg       <= '0;
                    first_row_reg <= 1'b0;
                end
                else
                begin
                    col_reg <= next_col[CW-1:0];
                end
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            // Update neighbors and maximum as a cell retires from stage one
            if (s1_adv)
            begin
                if (s1_last_reg || s1_wrap_reg)
                begin
                    left_reg <= '0;
                    diag_reg <= '0;
                end
                else
                begin
                    left_reg <= score;
                    diag_reg <= up;
                end
                max_reg <= s1_last_reg ? '0 : max_next;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_blocked_reg <= cell_in.blocked;
            s1_last_reg    <= cell_in.last_cell;
            s1_edge_reg    <= first_row_reg || (col_reg == '0);
            s1_wrap_reg    <= wrap;
            s1_col_reg     <= col_reg;
        end
        if (s1_adv)
        begin
            out_side_reg    <= score;
            out_largest_reg <= max_next;
            out_done_reg    <= s1_last_reg;
        end
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.square_side  = out_side_reg;
    assign result_out.largest_side = out_largest_reg;
    assign result_out.grid_done    = out_done_reg;

    // Check: the last cell restarts the position at the first row
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cell_in.last_cell |=> (col_reg == '0) && first_row_reg)
        else $error("position not restarted after last cell");

    // Check: the running maximum never falls below the cell's side
    a_max_covers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_largest_reg >= out_side_reg))
        else $error("largest side below square side");

    // Check: a held stage one blocks new cells
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |-> !accept)
        else $error("cell taken while stage one is held");

    // Check: a retiring cell always produces a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("result lost after stage one");

endmodule
